[rtl/core/iswi_pkg.sv]
// Shared constants for the integer sorter with index.
`default_nettype none
package iswi_pkg;
    localparam int MAX_ITEMS_DEF = 64;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 6;
endpackage
`default_nettype wire

[rtl/core/iswi_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module iswi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/core/integer_sorter_with_index_top.sv]
// Top level of the integer sorter with index: insertion sort in one RAM.
// Load: each accepted word is inserted by shifting the larger stored entries up one place;
// each shift is a RAM read then a write; a word that arrives with the store full is dropped.
// Emit: each word is a RAM read then the output register, and emit waits while the output
// register holds a word not yet taken.
// Input stays blocked until the final word of a set is taken.
// Reset (aresetn low, synchronous) clears state, count, overflow and output valid only.
`default_nettype none
module integer_sorter_with_index_top
    import iswi_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // value[31:0]
    input  wire logic        s_tlast,  // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // sorted_value[31:0], original_index[37:32], overflow[38]
    output logic             m_tlast   // last_out
);
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int EW = VALUE_W + AW;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_EMRD  = 3'd3;
    localparam logic [2:0] ST_EMOUT = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic               last_reg, last_next;
    logic               mv_reg, mv_next;
    logic [39:0]        md_reg, md_next;
    logic               ml_reg, ml_next;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [EW-1:0]      wdata, rdata;
    logic [VALUE_W-1:0] rval;
    logic [CW-1:0]      km1;

    iswi_ram #(.WIDTH(EW), .DEPTH(MAX_ITEMS)) u_store (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign rval = rdata[VALUE_W-1:0];
    assign km1 = k_reg - CW'(1);
    assign s_tready = (state_reg == ST_IDLE) && !mv_reg;
    assign m_tvalid = mv_reg;
    assign m_tdata = md_reg;
    assign m_tlast = ml_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        k_next = k_reg;
        val_next = val_reg;
        last_next = last_reg;
        mv_next = mv_reg && !m_tready;
        md_next = md_reg;
        ml_next = ml_reg;
        we = 1'b0;
        waddr = k_reg[AW-1:0];
        wdata = {count_reg[AW-1:0], val_reg};
        raddr = km1[AW-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    val_next = s_tdata;
                    last_next = s_tlast;
                    k_next = count_reg;
                    if (count_reg == CW'(MAX_ITEMS)) begin
                        ovf_next = 1'b1;
                        k_next = '0;
                        state_next = s_tlast ? ST_EMRD : ST_IDLE;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: begin
                // read entry k-1 if any
                if (k_reg == '0) begin
                    we = 1'b1;
                    count_next = count_reg + CW'(1);
                    k_next = '0;
                    state_next = last_reg ? ST_EMRD : ST_IDLE;
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if ($signed(val_reg) < $signed(rval)) begin
                    we = 1'b1;
                    wdata = rdata;
                    k_next = km1;
                    state_next = ST_RD;
                end else begin
                    we = 1'b1;
                    count_next = count_reg + CW'(1);
                    k_next = '0;
                    state_next = last_reg ? ST_EMRD : ST_IDLE;
                end
            end
            ST_EMRD: begin
                raddr = k_reg[AW-1:0];
                if (k_reg == count_reg) begin
                    count_next = '0;
                    ovf_next = 1'b0;
                    state_next = ST_IDLE;
                end else if (!mv_reg || m_tready) begin
                    state_next = ST_EMOUT;
                end
            end
            ST_EMOUT: begin
                mv_next = 1'b1;
                md_next = {1'b0, ovf_reg,
                           INDEX_W'(rdata[EW-1:VALUE_W]), rval};
                ml_next = (k_reg + CW'(1) == count_reg);
                k_next = k_reg + CW'(1);
                state_next = ST_EMRD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg <= ovf_next;
            mv_reg <= mv_next;
        end
        k_reg <= k_next;
        val_reg <= val_next;
        last_reg <= last_next;
        md_reg <= md_next;
        ml_reg <= ml_next;
    end
endmodule
`default_nettype wire

[sim/tb_top.sv]
// Testbench for the integer sorter with index: stable sort of value sets with load positions.
`timescale 1ns / 1ps
module tb_top
    import iswi_pkg::*;
();

    localparam int CAP = MAX_ITEMS_DEF;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        logic               ovf;
        logic               last;
    } sorted_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    integer_sorter_with_index_top #(.MAX_ITEMS(CAP)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // sorter state mirror
    logic [VALUE_W-1:0] held_value [CAP];
    logic [INDEX_W-1:0] held_index [CAP];
    int                 held_count;
    logic               dropped;

    sorted_word_t expected_words[$];
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  error_count;
    longint cycle_count;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // insert stably; on last, release the whole ordered set
    task automatic sort_insert(input logic [31:0] v, input logic is_last);
        int k;
        sorted_word_t w;
        if (held_count < CAP) begin
            k = held_count;
            while (k > 0 && $signed(v) < $signed(held_value[k-1])) begin
                held_value[k] = held_value[k-1];
                held_index[k] = held_index[k-1];
                k--;
            end
            held_value[k] = v;
            held_index[k] = held_count[INDEX_W-1:0];
            held_count++;
        end else begin
            dropped = 1'b1;
        end
        if (is_last) begin
            for (int i = 0; i < held_count; i++) begin
                w.value = held_value[i];
                w.index = held_index[i];
                w.ovf   = dropped;
                w.last  = (i == held_count - 1);
                expected_words.push_back(w);
            end
            held_count = 0;
            dropped = 1'b0;
        end
    endtask

    // valid drops after each word, for longer when idle cycles are drawn
    task automatic send_word(input logic [31:0] v, input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sort_insert(v, is_last);
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            2: return $urandom_range(7) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++) send_word(rand_value(), i == n - 1);
    endtask

    task automatic drain();
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_word(32'h0000_0005, 1'b1);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0000_0003, 1'b0);
        send_word(32'h0000_0003, 1'b0);
        send_word(32'h0000_0003, 1'b1);
        drain();
    endtask

    // full store, then past it: the closing word itself is dropped
    task automatic test_overflow();
        for (int i = 0; i < CAP; i++) send_word(32'(CAP - i), 1'b0);
        send_word(32'h1234_5678, 1'b0);
        send_word(32'h8765_4321, 1'b1);
        send_set(CAP);
        drain();
    endtask

    task automatic test_random(input int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(CAP + 2, CAP - 2)
                                         : $urandom_range(12, 1);
            send_set(n);
            sent += n;
        end
        drain();
    endtask

    // receiver stalls while a set of 20 is sent; a set of 5 follows once it is released
    task automatic test_backpressure();
        recv_hold = 1'b1;
        fork
            send_set(20);
            begin
                repeat (400) @(posedge aclk);
                recv_hold = 1'b0;
            end
        join
        send_set(5);
        drain();
    endtask

    always @(posedge aclk) begin
        m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        sorted_word_t w;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: data=%h last=%b", m_tdata, m_tlast);
                error_count++;
            end else begin
                w = expected_words.pop_front();
                if (m_tdata[31:0] !== w.value) begin
                    $error("sorted_value exp %h got %h", w.value, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[37:32] !== w.index) begin
                    $error("original_index exp %0d got %0d", w.index, m_tdata[37:32]);
                    error_count++;
                end
                if (m_tdata[38] !== w.ovf) begin
                    $error("overflow exp %b got %b", w.ovf, m_tdata[38]);
                    error_count++;
                end
                if (m_tlast !== w.last) begin
                    $error("last_out exp %b got %b", w.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        recv_hold = 1'b0;
        held_count = 0;
        dropped = 1'b0;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_overflow();
        send_idle_pct = 21; recv_idle_pct = 52;
        test_random(60);
        send_idle_pct = 52; recv_idle_pct = 21;
        test_random(60);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(50);
        test_backpressure();
        if (expected_words.size() != 0) begin
            $error("%0d expected words never arrived", expected_words.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

[files.f]
rtl/core/iswi_pkg.sv
rtl/core/iswi_ram.sv
rtl/core/integer_sorter_with_index_top.sv
sim/tb_top.sv
